// File: src/mtg_pkg.sv
// ---------------------------------------------------------------------------
// Multitouch gesture decoder package
// Shared codes, types and register indices for the gesture decoder.
// ---------------------------------------------------------------------------
package mtg_pkg;

  localparam int CoordWidthDef = 12;

  localparam logic [4:0] EvtSync = 5'd0;
  localparam logic [4:0] EvtAbs  = 5'd3;
  localparam logic [9:0] CodeReport = 10'h000;
  localparam logic [9:0] CodeSlot   = 10'h02F;
  localparam logic [9:0] CodeTrack  = 10'h039;
  localparam logic [9:0] CodePosX   = 10'h035;
  localparam logic [9:0] CodePosY   = 10'h036;

  localparam logic [2:0] ActDown  = 3'd0;
  localparam logic [2:0] ActUp    = 3'd1;
  localparam logic [2:0] ActMove  = 3'd2;
  localparam logic [2:0] ActPdown = 3'd3;
  localparam logic [2:0] ActPup   = 3'd4;
  localparam logic [2:0] ActNone  = 3'd5;

  localparam logic [1:0] RegDispW  = 2'd0;
  localparam logic [1:0] RegDispH  = 2'd1;
  localparam logic [1:0] RegTouchW = 2'd2;
  localparam logic [1:0] RegTouchH = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// File: src/multitouch_event_to_gesture.sv
// ---------------------------------------------------------------------------
// Multitouch type-B event to gesture decoder
// Turns a stream of input event words into gesture record words.
// ---------------------------------------------------------------------------
// Usage: input event words arrive on the in_ channel (valid/stall); gesture
// records leave on the out_ channel. An event that needs no scaling is
// taken as soon as the input is not stalled. A position event is scaled by
// one shift-add multiplier followed by one restoring divider, both running
// on a single shared adder: 12 multiply steps, 48 divide steps and one
// write-back step, and the input stays stalled until they are done.
// The block takes no new word while a position is being scaled or while a
// finished record waits in the output register; a stalled record holds.
// A record is valid the cycle after the word that completes it, or, for a y
// position that completes a first contact, once its write-back step is done;
// it must be taken before the next word is accepted.
// The APB port (cfg_) writes the display and panel sizes and reads them back;
// write only while the block is idle. Reset (rst_n low, synchronous)
// returns the sizes to their defaults, clears the contact store to minus
// one and drops any waiting record.
// ---------------------------------------------------------------------------
module multitouch_event_to_gesture
  import mtg_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [4:0]         in_event_type,
  input  logic [9:0]         in_event_code,
  input  logic signed [31:0] in_event_value,
  input  logic [47:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_action,
  output logic signed [1:0]  out_action_index,
  output logic [1:0]         out_pointer_total,
  output logic signed [12:0] out_first_x,
  output logic signed [12:0] out_first_y,
  output logic signed [1:0]  out_first_slot,
  output logic signed [12:0] out_second_x,
  output logic signed [12:0] out_second_y,
  output logic signed [1:0]  out_second_slot,
  output logic signed [48:0] out_down_time_ms,
  output logic [47:0]        out_event_time_ms,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam logic [12:0] CoordMax = 13'((1 << COORD_WIDTH) - 1);

  // Configuration registers
  logic [11:0] disp_w_r, disp_h_r;
  logic [15:0] touch_w_r, touch_h_r;

  // Contact store and packet state
  logic signed [12:0] slot_x_r [2];
  logic signed [12:0] slot_y_r [2];
  logic signed [1:0]  map_r [2];
  logic               cur_slot_r;
  logic [1:0]         count_r;
  logic signed [48:0] down_r;
  logic signed [1:0]  pidx_r;
  logic signed [1:0]  paidx_r;
  logic [2:0]         pact_r;
  logic               seen_r;

  // Scaling unit: shared adder, multiply then divide
  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r;
  logic [47:0] acc_r;    // product, then quotient
  logic [31:0] mcand_r;  // raw value (non-negative)
  logic [11:0] mplier_r;
  logic [15:0] div_r;
  logic [16:0] rem_r;
  logic        is_y_r;
  logic        neg_r;
  logic        wslot_r;
  logic [47:0] now_r;

  // Output record register
  logic        ov_r;
  logic [2:0]  o_act_r;
  logic signed [1:0] o_aidx_r, o_s0_r, o_s1_r;
  logic [1:0]  o_tot_r;
  logic signed [12:0] o_x0_r, o_y0_r, o_x1_r, o_y1_r;
  logic signed [48:0] o_down_r;
  logic [47:0] o_time_r;

  logic accept;
  assign in_stall = (state_r != ST_IDLE) || ov_r;
  assign accept   = in_valid && !in_stall;

  // Configuration port
  logic [1:0] creg;
  assign creg = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;
  always_comb begin
    case (creg)
      RegDispW:  cfg_prdata = {20'd0, disp_w_r};
      RegDispH:  cfg_prdata = {20'd0, disp_h_r};
      RegTouchW: cfg_prdata = {16'd0, touch_w_r};
      RegTouchH: cfg_prdata = {16'd0, touch_h_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_w_r  <= 12'd758;
      disp_h_r  <= 12'd1024;
      touch_w_r <= 16'd4095;
      touch_h_r <= 16'd4095;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      case (creg)
        RegDispW:  disp_w_r  <= cfg_pwdata[11:0];
        RegDispH:  disp_h_r  <= cfg_pwdata[11:0];
        RegTouchW: touch_w_r <= cfg_pwdata[15:0];
        RegTouchH: touch_h_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Shared adder: multiply accumulates, divide trial-subtracts
  logic        div_step;
  logic [47:0] add_a, add_b, add_sum;
  logic [47:0] mul_sum;
  logic [16:0] trial;
  logic [16:0] rem_sh;
  assign div_step = (state_r == ST_DIV);
  assign rem_sh   = {rem_r[15:0], acc_r[47]};
  assign add_a    = div_step ? {31'd0, rem_sh} : acc_r;
  assign add_b    = div_step ? {31'd0, ~{1'b0, div_r}} :
                    (mplier_r[0] ? ({16'd0, mcand_r} << cnt_r[4:0]) : 48'd0);
  assign add_sum  = add_a + add_b + {47'd0, div_step};
  assign mul_sum  = add_sum;
  assign trial    = add_sum[16:0];

  // Clamp of the finished quotient
  logic [12:0] hi;
  logic [11:0] dsel;
  logic [12:0] scaled;
  assign dsel = is_y_r ? disp_h_r : disp_w_r;
  always_comb begin
    hi = (dsel == 12'd0) ? 13'd0 : {1'b0, dsel} - 13'd1;
    if (hi > CoordMax) hi = CoordMax;
    if (neg_r) scaled = 13'd0;
    else if (acc_r > {35'd0, hi}) scaled = hi;
    else scaled = acc_r[12:0];
  end

  // Next state of the sequencer
  logic start_scale;
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start_scale) state_nxt = ST_MUL;
      ST_MUL:  if (cnt_r == 6'd11) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 6'd47) state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Decode of the accepted word
  logic is_evt, is_abs, is_sync, is_pos, is_x;
  assign is_evt  = !in_kind;
  assign is_sync = is_evt && in_event_type == EvtSync && in_event_code == CodeReport
                   && in_event_value == 32'sd0;
  assign is_abs  = is_evt && in_event_type == EvtAbs;
  assign is_pos  = is_abs && (in_event_code == CodePosX || in_event_code == CodePosY);
  assign is_x    = in_event_code == CodePosX;
  assign start_scale = accept && is_pos;

  // Event processing: packet state updates and record emission
  always_ff @(posedge clk) begin : proc_main
    logic signed [1:0] pi, pai, s0, s1;
    logic [1:0] cc, tot;
    logic [2:0] act;
    logic sl, seen, emit, fin;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 6'd0;
      for (int i = 0; i < 2; i++) begin
        slot_x_r[i] <= -13'sd1;
        slot_y_r[i] <= -13'sd1;
        map_r[i]    <= -2'sd1;
      end
      cur_slot_r <= 1'b0;
      count_r    <= 2'd0;
      down_r     <= -49'sd1;
      pidx_r     <= -2'sd1;
      paidx_r    <= -2'sd1;
      pact_r     <= ActNone;
      seen_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      pi = pidx_r; pai = paidx_r; cc = count_r; act = pact_r; sl = cur_slot_r;
      seen = seen_r;
      fin = 1'b0;
      if (accept) begin
        now_r <= in_now_ms;
        if (!is_evt || is_sync) fin = 1'b1;
        if (is_abs) begin
          seen = 1'b1;
          if (in_event_code == CodeSlot) begin
            if (in_event_value == 32'sd0 || in_event_value == 32'sd1)
              cur_slot_r <= in_event_value[0];
          end else if (in_event_code == CodeTrack && in_event_value >= -32'sd1) begin
            if (pi < 2'sd1) pi = pi + 2'sd1;
            map_r[pi[0]] <= {1'b0, sl};
            pai = pi;
            if (in_event_value >= 0) begin
              if (cc < 2'd2) cc = cc + 2'd1;
              if (cc == 2'd1) begin
                act = ActDown;
                down_r <= {1'b0, in_now_ms};
              end else act = ActPdown;
            end else begin
              if (cc > 2'd0) cc = cc - 2'd1;
              if (cc == 2'd1) begin
                act = ActPup;
                fin = 1'b1;
              end else act = ActUp;
            end
            count_r <= cc;
          end else if (is_pos) begin
            if (pi < 2'sd0 || map_r[pi[0]] != {1'b0, sl}) begin
              if (pi < 2'sd1) pi = pi + 2'sd1;
              map_r[pi[0]] <= {1'b0, sl};
            end
            if (pai < 2'sd0) pai = pi;
            if (act == ActNone) act = ActMove;
            // Load the scaling unit
            is_y_r  <= !is_x;
            wslot_r <= sl;
            neg_r   <= in_event_value[31];
            mcand_r <= in_event_value[31] ? 32'd0 : in_event_value;
            mplier_r <= is_x ? disp_w_r : disp_h_r;
            div_r   <= is_x ? ((touch_w_r == 16'd0) ? 16'd1 : touch_w_r)
                            : ((touch_h_r == 16'd0) ? 16'd1 : touch_h_r);
            acc_r   <= 48'd0;
            cnt_r   <= 6'd0;
          end
        end
      end
      // Scaling iterations
      case (state_r)
        ST_MUL: begin
          acc_r    <= mul_sum;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= (cnt_r == 6'd11) ? 6'd0 : cnt_r + 6'd1;
          rem_r    <= 17'd0;
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (!trial[16]) begin
            rem_r <= trial;
            acc_r <= {acc_r[46:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            acc_r <= {acc_r[46:0], 1'b0};
          end
        end
        ST_OUT: begin
          if (is_y_r) slot_y_r[wslot_r] <= scaled;
          else slot_x_r[wslot_r] <= scaled;
          if (is_y_r && act == ActDown) fin = 1'b1;
        end
        default: ;
      endcase
      // Packet end: build the record
      if (fin) begin
        emit = seen;
        tot = 2'(pi + 2'sd1);
        s0 = (tot >= 2'd1) ? ((pi[0] == 1'b0 && pi >= 0) ? {1'b0, sl} : map_r[0]) : -2'sd1;
        s1 = (tot >= 2'd2) ? ((pi == 2'sd1) ? {1'b0, sl} : map_r[1]) : -2'sd1;
        // Map entries written this cycle are only for the current index
        if (!(accept && in_event_code == CodeTrack && is_abs)) begin
          s0 = (tot >= 2'd1) ? map_r[0] : -2'sd1;
          s1 = (tot >= 2'd2) ? map_r[1] : -2'sd1;
        end
        if (pi == 2'sd0 && (cc == 2'd2 || act == ActPup)) begin
          s1 = {1'b0, ~s0[0]};
          tot = 2'd2;
        end
        if (emit) begin
          ov_r     <= 1'b1;
          o_act_r  <= act;
          o_aidx_r <= pai;
          o_tot_r  <= tot;
          o_s0_r   <= s0;
          o_s1_r   <= s1;
          o_x0_r   <= (s0 < 0) ? -13'sd1 : slot_x_r[s0[0]];
          o_y0_r   <= (s0 < 0) ? -13'sd1 :
                      ((state_r == ST_OUT && s0[0] == wslot_r) ? scaled : slot_y_r[s0[0]]);
          o_x1_r   <= (s1 < 0) ? -13'sd1 : slot_x_r[s1[0]];
          o_y1_r   <= (s1 < 0) ? -13'sd1 :
                      ((state_r == ST_OUT && s1[0] == wslot_r) ? scaled : slot_y_r[s1[0]]);
          o_down_r <= down_r;
          o_time_r <= accept ? in_now_ms : now_r;
          if (act == ActUp) begin
            cur_slot_r <= 1'b0;
            count_r    <= 2'd0;
          end
        end
        pi   = -2'sd1;
        pai  = -2'sd1;
        act  = ActNone;
        seen = 1'b0;
      end
      // Packet state for the next word
      pidx_r  <= pi;
      paidx_r <= pai;
      pact_r  <= act;
      seen_r  <= seen;
    end
  end

  // Output ports
  assign out_valid         = ov_r;
  assign out_action        = o_act_r;
  assign out_action_index  = o_aidx_r;
  assign out_pointer_total = o_tot_r;
  assign out_first_x       = o_x0_r;
  assign out_first_y       = o_y0_r;
  assign out_first_slot    = o_s0_r;
  assign out_second_x      = o_x1_r;
  assign out_second_y      = o_y1_r;
  assign out_second_slot   = o_s1_r;
  assign out_down_time_ms  = o_down_r;
  assign out_event_time_ms = o_time_r;

endmodule

// File: sim/tb_multitouch_event_to_gesture.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the multitouch event to gesture decoder
// Drives event words into the block, predicts every gesture record from an
// internal model of the contact store and compares each record field by
// field. The run covers directed corner cases, random gesture sequences
// under several idling phases, size settings at their extremes and a long
// receiver hold-off that fills the block.
// ---------------------------------------------------------------------------
module tb_multitouch_event_to_gesture;
  import mtg_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 250;
  localparam int HoldOffCycles = 400;

  typedef struct {
    logic [2:0]         action;
    logic signed [1:0]  action_index;
    logic [1:0]         pointer_total;
    logic signed [12:0] first_x;
    logic signed [12:0] first_y;
    logic signed [1:0]  first_slot;
    logic signed [12:0] second_x;
    logic signed [12:0] second_y;
    logic signed [1:0]  second_slot;
    logic signed [48:0] down_time_ms;
    logic [47:0]        event_time_ms;
  } gesture_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [4:0] in_event_type = '0;
  logic [9:0] in_event_code = '0;
  logic signed [31:0] in_event_value = '0;
  logic [47:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_action;
  logic signed [1:0] out_action_index;
  logic [1:0] out_pointer_total;
  logic signed [12:0] out_first_x, out_first_y, out_second_x, out_second_y;
  logic signed [1:0] out_first_slot, out_second_slot;
  logic signed [48:0] out_down_time_ms;
  logic [47:0] out_event_time_ms;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  multitouch_event_to_gesture dut (.*);

  always #5 clk = ~clk;

  // Mirror of the size registers and of the contact store.
  logic [11:0] disp_w, disp_h;
  logic [15:0] span_w, span_h;
  logic signed [12:0] pos_x[2], pos_y[2];
  logic signed [1:0] index_map[2];
  logic cur_slot;
  logic [1:0] contacts;
  logic signed [48:0] down_stamp;
  logic signed [1:0] pk_index, pk_action_index;
  logic [2:0] pk_action;
  logic pk_seen_abs;

  gesture_t pending_gestures[$];
  int errors = 0;
  int words_sent = 0;
  int records_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  logic [47:0] clock_ms = 48'd1000;

  function automatic logic signed [12:0] scale_axis(logic signed [31:0] raw,
                                                    logic [11:0] disp,
                                                    logic [15:0] span);
    longint dv, q, hi;
    dv = (span == 0) ? 1 : longint'(span);
    q = (longint'(disp) * longint'(raw)) / dv;
    hi = (disp == 0) ? 0 : longint'(disp) - 1;
    if (hi > 4095) hi = 4095;
    if (q < 0) q = 0;
    if (q > hi) q = hi;
    return q[12:0];
  endfunction

  function automatic void clear_packet();
    pk_index = -1;
    pk_action_index = -1;
    pk_action = ActNone;
    pk_seen_abs = 1'b0;
  endfunction

  function automatic void reset_store();
    disp_w = 12'd758;
    disp_h = 12'd1024;
    span_w = 16'd4095;
    span_h = 16'd4095;
    for (int i = 0; i < 2; i++) begin
      pos_x[i] = -1;
      pos_y[i] = -1;
      index_map[i] = -1;
    end
    cur_slot = 1'b0;
    contacts = 2'd0;
    down_stamp = -1;
    clear_packet();
  endfunction

  function automatic void advance_index();
    if (pk_index < 1) pk_index = pk_index + 1;
    index_map[pk_index[0]] = $signed({1'b0, cur_slot});
  endfunction

  function automatic void fill_pointer(int slot, output logic signed [12:0] x,
                                       output logic signed [12:0] y,
                                       output logic signed [1:0] s);
    if (slot < 0 || slot > 1) begin
      x = -1;
      y = -1;
      s = -1;
    end else begin
      x = pos_x[slot];
      y = pos_y[slot];
      s = slot;
    end
  endfunction

  // End of a packet: one record if any absolute event was seen.
  function automatic void close_packet(logic [47:0] now);
    gesture_t rec;
    int total, s0, s1;
    if (!pk_seen_abs) begin
      clear_packet();
      return;
    end
    total = int'(pk_index) + 1;
    s0 = -1;
    s1 = -1;
    if (total >= 1) s0 = index_map[0];
    if (total >= 2) s1 = index_map[1];
    if (pk_index == 0 && (contacts == 2 || pk_action == ActPup)) begin
      s1 = 1 - (s0 & 1);
      total = 2;
    end
    rec.action = pk_action;
    rec.action_index = pk_action_index;
    rec.pointer_total = total[1:0];
    fill_pointer(s0, rec.first_x, rec.first_y, rec.first_slot);
    fill_pointer(s1, rec.second_x, rec.second_y, rec.second_slot);
    rec.down_time_ms = down_stamp;
    rec.event_time_ms = now;
    if (pk_action == ActUp) begin
      cur_slot = 1'b0;
      contacts = 2'd0;
    end
    clear_packet();
    pending_gestures.push_back(rec);
  endfunction

  // Predicts the effect of one accepted event word.
  function automatic void decode_word(logic kind, logic [4:0] etype, logic [9:0] code,
                                      logic signed [31:0] value, logic [47:0] now);
    if (kind) begin
      close_packet(now);
      return;
    end
    if (etype == EvtSync) begin
      if (code == CodeReport && value == 0) close_packet(now);
      return;
    end
    if (etype != EvtAbs) return;
    pk_seen_abs = 1'b1;
    if (code == CodeSlot) begin
      if (value == 0 || value == 1) cur_slot = value[0];
    end else if (code == CodeTrack) begin
      if (value >= 0) begin
        advance_index();
        if (contacts < 2) contacts = contacts + 1;
        if (contacts == 1) begin
          pk_action = ActDown;
          down_stamp = $signed({1'b0, now});
        end else if (contacts == 2) begin
          pk_action = ActPdown;
        end
        pk_action_index = pk_index;
      end else if (value == -1) begin
        advance_index();
        if (contacts > 0) contacts = contacts - 1;
        pk_action_index = pk_index;
        if (contacts == 1) begin
          pk_action = ActPup;
          close_packet(now);
        end else begin
          pk_action = ActUp;
        end
      end
    end else if (code == CodePosX || code == CodePosY) begin
      if (pk_index < 0 || int'(index_map[pk_index[0]]) != int'(cur_slot)) advance_index();
      if (pk_action_index < 0) pk_action_index = pk_index;
      if (code == CodePosX) pos_x[cur_slot] = scale_axis(value, disp_w, span_w);
      else pos_y[cur_slot] = scale_axis(value, disp_h, span_h);
      if (pk_action == ActNone) pk_action = ActMove;
      if (code == CodePosY && pk_action == ActDown) close_packet(now);
    end
  endfunction

  // Sends one event word; called and returning at a rising edge.
  task automatic send_word(logic kind, logic [4:0] etype, logic [9:0] code,
                           logic signed [31:0] value, logic [47:0] now);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_event_type <= etype;
    in_event_code <= code;
    in_event_value <= value;
    in_now_ms <= now;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    decode_word(kind, etype, code, value, now);
    words_sent++;
    @(posedge clk);
  endtask

  task automatic send_abs(logic [9:0] code, logic signed [31:0] value);
    clock_ms = clock_ms + $urandom_range(0, 40);
    send_word(1'b0, EvtAbs, code, value, clock_ms);
  endtask

  task automatic send_report();
    clock_ms = clock_ms + $urandom_range(0, 40);
    send_word(1'b0, EvtSync, CodeReport, 32'sd0, clock_ms);
  endtask

  // Waits for all records, then for the block to finish any scaling.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_size(logic [1:0] reg_index, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (reg_index)
      RegDispW:  disp_w = value[11:0];
      RegDispH:  disp_h = value[11:0];
      RegTouchW: span_w = value[15:0];
      default:   span_h = value[15:0];
    endcase
  endtask

  task automatic set_sizes(logic [31:0] dw, logic [31:0] dh, logic [31:0] tw,
                           logic [31:0] th);
    settle();
    write_size(RegDispW, dw);
    write_size(RegDispH, dh);
    write_size(RegTouchW, tw);
    write_size(RegTouchH, th);
  endtask

  function automatic logic signed [31:0] pick_raw(logic [15:0] span);
    int r;
    r = $urandom_range(99);
    if (r < 8) return -$signed({1'b0, 31'($urandom_range(1, 5000))});
    if (r < 14) return $urandom;
    return $urandom_range(0, int'(span) + int'(span) / 8 + 1);
  endfunction

  // One random packet: mostly well-formed gesture steps, some noise.
  task automatic random_packet();
    int pick;
    logic [47:0] stamp;
    pick = $urandom_range(99);
    if (pick < 22) begin
      send_abs(CodeSlot, $urandom_range(0, 1));
      send_abs(CodeTrack, $urandom_range(0, 65535));
      send_abs(CodePosX, pick_raw(span_w));
      send_abs(CodePosY, pick_raw(span_h));
      send_report();
    end else if (pick < 50) begin
      if ($urandom_range(1)) send_abs(CodeSlot, $urandom_range(0, 1));
      if ($urandom_range(3) != 0) send_abs(CodePosX, pick_raw(span_w));
      if ($urandom_range(3) != 0) send_abs(CodePosY, pick_raw(span_h));
      if ($urandom_range(1)) begin
        send_abs(CodeSlot, $urandom_range(0, 1));
        send_abs(CodePosX, pick_raw(span_w));
      end
      send_report();
    end else if (pick < 72) begin
      send_abs(CodeSlot, $urandom_range(0, 1));
      send_abs(CodeTrack, -32'sd1);
      if ($urandom_range(2) == 0) send_abs(CodeTrack, -32'sd1);
      send_report();
    end else if (pick < 80) begin
      send_abs(CodeSlot, $urandom);
      send_abs(CodeTrack, $urandom);
      send_abs(CodeSlot, $urandom_range(0, 1));
      send_abs(CodeTrack, $urandom_range(0, 3));
      send_report();
    end else if (pick < 88) begin
      stamp = {$urandom, $urandom};
      send_word(1'b1, 5'($urandom), 10'($urandom), $urandom, stamp);
    end else begin
      stamp = {$urandom, $urandom};
      send_word($urandom_range(0, 1) == 0, 5'($urandom), 10'($urandom), $urandom, stamp);
      if ($urandom_range(1)) send_word(1'b0, EvtAbs, 10'($urandom_range(0, 63)),
                                       $urandom, stamp);
    end
  endtask

  task automatic run_random(int words);
    int target;
    target = words_sent + words;
    while (words_sent < target) random_packet();
  endtask

  // Directed corner cases with default sizes.
  task automatic test_directed();
    send_word(1'b1, EvtSync, CodeReport, 32'sd0, 48'd5);
    send_word(1'b0, 5'd31, 10'd1023, 32'sh7fffffff, 48'hffff_ffff_ffff);
    send_abs(CodeSlot, 32'sd0);
    send_abs(CodeTrack, 32'sd5);
    send_abs(CodePosX, 32'sd0);
    send_abs(CodePosY, 32'sd4095);
    send_report();
    send_abs(CodeSlot, 32'sd1);
    send_abs(CodeTrack, 32'sd7);
    send_abs(CodePosX, 32'sh7fffffff);
    send_abs(CodePosY, 32'sh80000000);
    send_report();
    send_abs(CodeSlot, 32'sd1);
    send_abs(CodeTrack, -32'sd1);
    send_abs(CodeSlot, 32'sd5);
    send_abs(CodeTrack, -32'sd2);
    send_abs(CodePosX, 32'sd2000);
    send_word(1'b0, EvtSync, CodeReport, 32'sd1, clock_ms);
    send_word(1'b0, EvtSync, 10'd2, 32'sd0, clock_ms);
    send_word(1'b0, 5'd1, CodeTrack, 32'sd0, clock_ms);
    send_report();
    send_abs(CodeSlot, 32'sd0);
    send_abs(CodeTrack, -32'sd1);
    send_abs(CodeTrack, -32'sd1);
    send_word(1'b1, 5'd0, 10'd0, 32'sd0, 48'h8000_0000_0001);
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(150);
    send_idle_pct = 88;
    run_random(90);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    run_random(90);
    send_idle_pct = 28;
    recv_stall_pct = 28;
    run_random(120);
  endtask

  task automatic test_size_extremes();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    set_sizes(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    run_random(70);
    set_sizes(32'd1, 32'd1, 32'd1, 32'd1);
    run_random(50);
    set_sizes(32'd0, 32'd0, 32'd0, 32'd0);
    run_random(40);
    set_sizes($urandom_range(1, 4095), $urandom_range(1, 4095),
              $urandom_range(1, 65535), $urandom_range(1, 300));
    run_random(60);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    run_random(40);
  endtask

  // Receiver: random stall, with one long hold-off on request.
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HoldOffCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s expected %0h got %0h", name, exp_val, got_val);
      errors++;
    end
  endtask

  // Checks each record word as it is taken.
  always @(negedge clk) begin
    gesture_t want;
    if (rst_n && out_valid && !out_stall) begin
      records_seen++;
      if (pending_gestures.size() == 0) begin
        $error("record with no expectation, action %0d", out_action);
        errors++;
      end else begin
        want = pending_gestures.pop_front();
        compare_field("action", want.action, out_action);
        compare_field("action_index", want.action_index, out_action_index);
        compare_field("pointer_total", want.pointer_total, out_pointer_total);
        compare_field("first_x", want.first_x, out_first_x);
        compare_field("first_y", want.first_y, out_first_y);
        compare_field("first_slot", want.first_slot, out_first_slot);
        compare_field("second_x", want.second_x, out_second_x);
        compare_field("second_y", want.second_y, out_second_y);
        compare_field("second_slot", want.second_slot, out_second_slot);
        compare_field("down_time_ms", want.down_time_ms, out_down_time_ms);
        compare_field("event_time_ms", want.event_time_ms, out_event_time_ms);
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel and no configuration access.
  int quiet_cycles = 0;
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no word moved for %0d cycles", WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_store();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_idle_phases();
    test_backpressure();
    test_size_extremes();
    settle();
    if (pending_gestures.size() != 0) begin
      $error("%0d records never arrived", pending_gestures.size());
      errors++;
    end
    $display("Sent %0d event words and checked %0d gesture records", words_sent,
             records_seen);
    $display("over idling phases, a long output hold-off and size extremes.");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
src/mtg_pkg.sv
src/multitouch_event_to_gesture.sv
sim/tb_multitouch_event_to_gesture.sv
